// File: design/rlse_pkg.sv
// Shared types and constants for the run-length sequence editor.
// Used by rlse_ctrl, rlse_dp and run_length_sequence_editor; no dependencies.
package rlse_pkg;

  localparam int unsigned MAX_RUNS_DEF    = 64;
  localparam int unsigned SYMBOL_BITS_DEF = 3;
  localparam int unsigned COUNT_BITS_DEF  = 16;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam logic [5:0]  BTOT_MAX        = 6'd63;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK   = 3'd0,
    CMD_PUSH_FRONT  = 3'd1,
    CMD_POP_BACK    = 3'd2,
    CMD_POP_FRONT   = 3'd3,
    CMD_CHANGE_NTH  = 3'd4,
    CMD_CHANGE_BND  = 3'd5,
    CMD_QUERY       = 3'd6,
    CMD_RESTART     = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_LEN   = 1'b0,
    CFG_INIT_STATE = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_READ_END, OP_END_USE, OP_READ_SCAN, OP_SCAN,
    OP_READ_PREV, OP_CAP_PREV, OP_READ_NEXT, OP_CAP_NEXT, OP_PLAN, OP_TOT_INC,
    OP_SHIFT_INIT, OP_READ_SHIFT, OP_WRITE_SHIFT, OP_FILL, OP_RESIZE, OP_RESTART,
    OP_READ_FRONT, OP_READ_BACK, OP_CAP_BACK, OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    cmd_e        command;
    logic [2:0]  wr_sym;
    logic [2:0]  key_sym;
    logic [2:0]  neighbour_state;
    logic [15:0] nth;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  popped_state;
    logic [15:0] total_length;
    logic [15:0] state_total;
    logic [5:0]  boundary_total;
    logic [2:0]  back_end_state;
    logic [2:0]  front_end_state;
    status_e     status;
  } out_item_t;

  typedef struct packed {
    cmd_e cmd;
    logic n_zero;
    logic len_full;
    logic end_splice;
    logic hit;
    logic last;
    logic plan_go;
    logic no_shift;
    logic moves_last;
    logic fill_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: design/rlse_dp.sv
// Datapath of the run-length sequence editor: run memory, totals, scan,
// splice and output registers. Depends on rlse_pkg; driven by rlse_ctrl.
module rlse_dp #(
  parameter int unsigned MAX_RUNS    = rlse_pkg::MAX_RUNS_DEF,
  parameter int unsigned SYMBOL_BITS = rlse_pkg::SYMBOL_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rlse_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rlse_pkg::dp_op_e                 op_i,
  output rlse_pkg::dp_stat_t               stat_o,
  input  rlse_pkg::in_item_t               in_item_i,
  input  logic                             cfg_we_i,
  input  logic [rlse_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rlse_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output rlse_pkg::out_item_t              out_item_o
);

  localparam int unsigned IW   = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned NW   = $clog2(MAX_RUNS + 1);
  localparam int unsigned SB   = SYMBOL_BITS;
  localparam int unsigned CB   = COUNT_BITS;
  localparam int unsigned NSYM = 1 << SYMBOL_BITS;
  localparam int unsigned EW   = SB + CB;
  localparam int unsigned WW   = (CB > 16) ? CB : 16;
  localparam logic [CB-1:0] CNT_MAX = '1;
  localparam logic [32:0]   CMAX33  = (33'd1 << COUNT_BITS) - 33'd1;

  rlse_pkg::in_item_t  item_q;
  rlse_pkg::out_item_t out_q;
  rlse_pkg::status_e   status_q;
  rlse_pkg::cmd_e      cmd;

  logic [EW-1:0] run_mem_q [MAX_RUNS];
  logic [EW-1:0] rdata_q, cur_q, pv_q, nx_q;
  logic [EW-1:0] e_q [3];
  logic [NW-1:0] n_q, moves_q;
  logic [CB-1:0] total_q, pos_q;
  logic [CB-1:0] tot_q [NSYM];
  logic [15:0]   cfg_len_q;
  logic [2:0]    cfg_sym_q, popped_q;
  logic [IW-1:0] i_q, fidx_q, f_q;
  logic [WW-1:0] inst_q;
  logic [SB-1:0] prev_q, front_q, back_q;
  logic [5:0]    btot_q;
  logic [1:0]    r_q, np_q, k_q;
  logic          out_valid_q;

  logic [SB-1:0] ns, os, nb, rd_sym, c_sym, pv_sym, nx_sym, tot_idx, rs_sym;
  logic [CB-1:0] rd_cnt, c_cnt, pv_cnt, nx_cnt, tot_rd, right, unit, rst_len;
  logic [IW-1:0] nm1, end_idx, raddr, waddr;
  logic [EW-1:0] wdata;
  logic          re, we, is_push, back_end, end_merge, push_new;
  logic          match_pair, found4, found5, mp, mn, has_next, noop, room, go;
  logic          shift_up;
  logic [1:0]    p_np, p_r, shift_dist;
  logic [NW:0]   new_n;
  logic [NW-1:0] tail;
  logic [32:0]   len_ext;

  assign cmd      = item_q.command;
  assign ns       = SB'(item_q.wr_sym);
  assign os       = SB'(item_q.key_sym);
  assign nb       = SB'(item_q.neighbour_state);
  assign rd_sym   = rdata_q[CB +: SB];
  assign rd_cnt   = rdata_q[CB-1:0];
  assign c_sym    = cur_q[CB +: SB];
  assign c_cnt    = cur_q[CB-1:0];
  assign pv_sym   = pv_q[CB +: SB];
  assign pv_cnt   = pv_q[CB-1:0];
  assign nx_sym   = nx_q[CB +: SB];
  assign nx_cnt   = nx_q[CB-1:0];
  assign rs_sym   = SB'(cfg_sym_q);
  assign len_ext  = 33'(cfg_len_q);
  assign rst_len  = (len_ext > CMAX33) ? CB'(CMAX33) : CB'(len_ext);

  assign is_push  = (cmd == rlse_pkg::CMD_PUSH_BACK) || (cmd == rlse_pkg::CMD_PUSH_FRONT);
  assign back_end = (cmd == rlse_pkg::CMD_PUSH_BACK) || (cmd == rlse_pkg::CMD_POP_BACK);
  assign nm1      = IW'(n_q - NW'(1));
  assign end_idx  = back_end ? nm1 : '0;

  // end run handling for push and pop
  assign end_merge = (n_q != '0) && (rd_sym == ns);
  assign push_new  = !end_merge && (n_q < NW'(MAX_RUNS));

  // scan matches
  assign match_pair = (i_q != '0) && (prev_q == nb) && (rd_sym == os);
  assign found4     = (rd_sym == os) && (inst_q < WW'(rd_cnt));
  assign found5     = match_pair && (inst_q == '0);

  // rewrite plan around the hit unit
  assign right    = c_cnt - pos_q - CB'(1);
  assign has_next = (NW'(fidx_q) + NW'(1)) < n_q;
  assign mp       = (pos_q == '0) && (fidx_q != '0) && (pv_sym == ns);
  assign mn       = (right == '0) && has_next && (nx_sym == ns);
  assign unit     = CB'(1) + (mp ? pv_cnt : '0) + (mn ? nx_cnt : '0);
  assign p_np     = 2'(pos_q != '0) + 2'd1 + 2'(right != '0);
  assign p_r      = 2'd1 + 2'(mp) + 2'(mn);
  assign new_n    = (NW+1)'(n_q) + (NW+1)'(p_np) - (NW+1)'(p_r);
  assign room     = new_n <= (NW+1)'(MAX_RUNS);
  assign noop     = (ns == c_sym);
  assign go       = !noop && room;

  // tail move
  assign shift_up   = np_q > r_q;
  assign shift_dist = shift_up ? (np_q - r_q) : (r_q - np_q);
  assign tail       = n_q - NW'(f_q) - NW'(r_q);

  always_comb begin
    case (op_i)
      rlse_pkg::OP_END_USE: tot_idx = is_push ? ns : rd_sym;
      rlse_pkg::OP_PLAN:    tot_idx = c_sym;
      rlse_pkg::OP_TOT_INC: tot_idx = ns;
      default:              tot_idx = os;
    endcase
  end
  assign tot_rd = tot_q[tot_idx];

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (op_i)
      rlse_pkg::OP_READ_END:   begin re = 1'b1; raddr = end_idx; end
      rlse_pkg::OP_READ_SCAN:  begin re = 1'b1; raddr = i_q; end
      rlse_pkg::OP_READ_PREV:  begin re = 1'b1; raddr = fidx_q - IW'(1); end
      rlse_pkg::OP_READ_NEXT:  begin re = 1'b1; raddr = fidx_q + IW'(1); end
      rlse_pkg::OP_READ_SHIFT: begin re = 1'b1; raddr = i_q; end
      rlse_pkg::OP_READ_FRONT: begin re = 1'b1; raddr = '0; end
      rlse_pkg::OP_READ_BACK:  begin re = 1'b1; raddr = nm1; end
      rlse_pkg::OP_END_USE: begin
        waddr = end_idx;
        if (is_push) begin
          we    = end_merge;
          wdata = {ns, rd_cnt + CB'(1)};
        end else begin
          we    = rd_cnt > CB'(1);
          wdata = {rd_sym, rd_cnt - CB'(1)};
        end
      end
      rlse_pkg::OP_WRITE_SHIFT: begin
        we    = 1'b1;
        waddr = shift_up ? (i_q + IW'(shift_dist)) : (i_q - IW'(shift_dist));
        wdata = rdata_q;
      end
      rlse_pkg::OP_FILL: begin
        we    = k_q < np_q;
        waddr = f_q + IW'(k_q);
        wdata = e_q[k_q];
      end
      rlse_pkg::OP_RESTART: begin
        we    = rst_len != '0;
        waddr = '0;
        wdata = {rs_sym, rst_len};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      run_mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= run_mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= '0;
      total_q   <= '0;
      cfg_len_q <= '0;
      cfg_sym_q <= '0;
      for (int s = 0; s < NSYM; s++) tot_q[s] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rlse_pkg::CFG_INIT_LEN:   cfg_len_q <= cfg_data_i;
          rlse_pkg::CFG_INIT_STATE: cfg_sym_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      case (op_i)
        rlse_pkg::OP_END_USE: begin
          if (is_push) begin
            if (end_merge || push_new) begin
              total_q          <= total_q + CB'(1);
              tot_q[tot_idx]   <= tot_rd + CB'(1);
            end
          end else begin
            total_q          <= total_q - CB'(1);
            tot_q[tot_idx]   <= tot_rd - CB'(1);
          end
        end
        rlse_pkg::OP_PLAN: begin
          if (go) tot_q[tot_idx] <= tot_rd - CB'(1);
        end
        rlse_pkg::OP_TOT_INC: tot_q[tot_idx] <= tot_rd + CB'(1);
        rlse_pkg::OP_RESIZE:  n_q <= n_q - NW'(r_q) + NW'(np_q);
        rlse_pkg::OP_RESTART: begin
          for (int s = 0; s < NSYM; s++) begin
            tot_q[s] <= (SB'(s) == rs_sym) ? rst_len : '0;
          end
          total_q       <= rst_len;
          n_q           <= NW'(rst_len != '0);
        end
        default: ;
      endcase
    end
  end

  // item working registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      rlse_pkg::OP_CAPTURE: begin
        item_q   <= in_item_i;
        i_q      <= '0;
        btot_q   <= '0;
        popped_q <= '0;
        prev_q   <= '0;
        inst_q   <= WW'(in_item_i.nth);
        if (((in_item_i.command == rlse_pkg::CMD_PUSH_BACK) ||
             (in_item_i.command == rlse_pkg::CMD_PUSH_FRONT)) && (total_q == CNT_MAX)) begin
          status_q <= rlse_pkg::ST_FULL;
        end else if (((in_item_i.command == rlse_pkg::CMD_POP_BACK) ||
                      (in_item_i.command == rlse_pkg::CMD_POP_FRONT)) && (n_q == '0)) begin
          status_q <= rlse_pkg::ST_EMPTY;
        end else if ((in_item_i.command == rlse_pkg::CMD_CHANGE_NTH) ||
                     (in_item_i.command == rlse_pkg::CMD_CHANGE_BND)) begin
          status_q <= rlse_pkg::ST_NOT_FOUND;
        end else begin
          status_q <= rlse_pkg::ST_OK;
        end
      end
      rlse_pkg::OP_END_USE: begin
        if (is_push) begin
          f_q    <= back_end ? IW'(n_q) : '0;
          r_q    <= 2'd0;
          np_q   <= 2'd1;
          e_q[0] <= {ns, CB'(1)};
          if (!end_merge && !push_new) status_q <= rlse_pkg::ST_FULL;
        end else begin
          popped_q <= 3'(rd_sym);
          f_q      <= end_idx;
          r_q      <= 2'd1;
          np_q     <= 2'd0;
        end
      end
      rlse_pkg::OP_SCAN: begin
        prev_q <= rd_sym;
        i_q    <= i_q + IW'(1);
        if (cmd == rlse_pkg::CMD_CHANGE_NTH) begin
          if (found4) begin
            fidx_q <= i_q;
            pos_q  <= CB'(inst_q);
            cur_q  <= rdata_q;
          end else if (rd_sym == os) begin
            inst_q <= inst_q - WW'(rd_cnt);
          end
        end else if (cmd == rlse_pkg::CMD_CHANGE_BND) begin
          if (found5) begin
            fidx_q <= i_q;
            pos_q  <= '0;
            cur_q  <= rdata_q;
          end else if (match_pair) begin
            inst_q <= inst_q - WW'(1);
          end
        end else if (match_pair && (btot_q != rlse_pkg::BTOT_MAX)) begin
          btot_q <= btot_q + 6'd1;
        end
      end
      rlse_pkg::OP_CAP_PREV: pv_q <= rdata_q;
      rlse_pkg::OP_CAP_NEXT: nx_q <= rdata_q;
      rlse_pkg::OP_PLAN: begin
        status_q <= (noop || room) ? rlse_pkg::ST_OK : rlse_pkg::ST_FULL;
        f_q      <= fidx_q - IW'(mp);
        r_q      <= p_r;
        np_q     <= p_np;
        if (pos_q != '0) begin
          e_q[0] <= {c_sym, pos_q};
          e_q[1] <= {ns, unit};
          e_q[2] <= {c_sym, right};
        end else begin
          e_q[0] <= {ns, unit};
          e_q[1] <= {c_sym, right};
          e_q[2] <= {c_sym, right};
        end
      end
      rlse_pkg::OP_SHIFT_INIT: begin
        i_q     <= shift_up ? nm1 : (f_q + IW'(r_q));
        moves_q <= tail;
        k_q     <= 2'd0;
      end
      rlse_pkg::OP_WRITE_SHIFT: begin
        i_q     <= shift_up ? (i_q - IW'(1)) : (i_q + IW'(1));
        moves_q <= moves_q - NW'(1);
      end
      rlse_pkg::OP_FILL:      k_q <= k_q + 2'd1;
      rlse_pkg::OP_READ_BACK: front_q <= (n_q != '0) ? rd_sym : '0;
      rlse_pkg::OP_CAP_BACK:  back_q  <= (n_q != '0) ? rd_sym : '0;
      default: ;
    endcase
  end

  // output register, free to take the next result once drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == rlse_pkg::OP_LOAD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == rlse_pkg::OP_LOAD_OUT) begin
      out_q.popped_state    <= popped_q;
      out_q.total_length    <= 16'(total_q);
      out_q.state_total     <= 16'(tot_rd);
      out_q.boundary_total  <= (cmd == rlse_pkg::CMD_QUERY) ? btot_q : '0;
      out_q.back_end_state  <= 3'(back_q);
      out_q.front_end_state <= 3'(front_q);
      out_q.status          <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    stat_o            = '0;
    stat_o.cmd        = cmd;
    stat_o.n_zero     = n_q == '0;
    stat_o.len_full   = total_q == CNT_MAX;
    stat_o.end_splice = is_push ? push_new : (rd_cnt <= CB'(1));
    stat_o.hit        = ((cmd == rlse_pkg::CMD_CHANGE_NTH) && found4) ||
                        ((cmd == rlse_pkg::CMD_CHANGE_BND) && found5);
    stat_o.last       = NW'(i_q) == (n_q - NW'(1));
    stat_o.plan_go    = go;
    stat_o.no_shift   = (np_q == r_q) || (tail == '0);
    stat_o.moves_last = moves_q == NW'(1);
    stat_o.fill_last  = (3'(k_q) + 3'd1) >= 3'(np_q);
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

`ifndef SYNTH
  a_runs_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_RUNS))
    else $error("run count beyond store depth");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == rlse_pkg::OP_LOAD_OUT) |=> out_valid_q)
    else $error("result load did not raise valid");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == rlse_pkg::OP_LOAD_OUT) |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before taken");
  a_shift_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == rlse_pkg::OP_WRITE_SHIFT) |-> (moves_q != '0))
    else $error("tail move past end");
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == rlse_pkg::OP_SCAN) |-> (NW'(i_q) < n_q))
    else $error("scan beyond last run");
`endif

endmodule

// File: design/rlse_ctrl.sv
// Sequencer of the run-length sequence editor: one-hot state machine that
// steps rlse_dp through each item. Depends on rlse_pkg.
module rlse_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rlse_pkg::dp_stat_t stat_i,
  output rlse_pkg::dp_op_e   op_o
);

  typedef enum logic [21:0] {
    S_IDLE       = 22'h000001,
    S_DECODE     = 22'h000002,
    S_END_RD     = 22'h000004,
    S_END_USE    = 22'h000008,
    S_SCAN_RD    = 22'h000010,
    S_SCAN_USE   = 22'h000020,
    S_PREV_RD    = 22'h000040,
    S_PREV_USE   = 22'h000080,
    S_NEXT_RD    = 22'h000100,
    S_NEXT_USE   = 22'h000200,
    S_PLAN       = 22'h000400,
    S_TOT_INC    = 22'h000800,
    S_SHIFT_INIT = 22'h001000,
    S_SHIFT_RD   = 22'h002000,
    S_SHIFT_WR   = 22'h004000,
    S_FILL       = 22'h008000,
    S_RESIZE     = 22'h010000,
    S_RESTART    = 22'h020000,
    S_FRONT_RD   = 22'h040000,
    S_BACK_RD    = 22'h080000,
    S_BACK_USE   = 22'h100000,
    S_DONE       = 22'h200000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = rlse_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = rlse_pkg::OP_CAPTURE;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.cmd)
          rlse_pkg::CMD_PUSH_BACK, rlse_pkg::CMD_PUSH_FRONT:
            state_d = stat_i.len_full ? S_FRONT_RD : S_END_RD;
          rlse_pkg::CMD_POP_BACK, rlse_pkg::CMD_POP_FRONT:
            state_d = stat_i.n_zero ? S_FRONT_RD : S_END_RD;
          rlse_pkg::CMD_RESTART:
            state_d = S_RESTART;
          default:
            state_d = stat_i.n_zero ? S_FRONT_RD : S_SCAN_RD;
        endcase
      end
      S_END_RD: begin
        op_o    = rlse_pkg::OP_READ_END;
        state_d = S_END_USE;
      end
      S_END_USE: begin
        op_o    = rlse_pkg::OP_END_USE;
        state_d = stat_i.end_splice ? S_SHIFT_INIT : S_FRONT_RD;
      end
      S_SCAN_RD: begin
        op_o    = rlse_pkg::OP_READ_SCAN;
        state_d = S_SCAN_USE;
      end
      S_SCAN_USE: begin
        op_o = rlse_pkg::OP_SCAN;
        if (stat_i.hit) begin
          state_d = S_PREV_RD;
        end else if (stat_i.last) begin
          state_d = S_FRONT_RD;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_PREV_RD: begin
        op_o    = rlse_pkg::OP_READ_PREV;
        state_d = S_PREV_USE;
      end
      S_PREV_USE: begin
        op_o    = rlse_pkg::OP_CAP_PREV;
        state_d = S_NEXT_RD;
      end
      S_NEXT_RD: begin
        op_o    = rlse_pkg::OP_READ_NEXT;
        state_d = S_NEXT_USE;
      end
      S_NEXT_USE: begin
        op_o    = rlse_pkg::OP_CAP_NEXT;
        state_d = S_PLAN;
      end
      S_PLAN: begin
        op_o    = rlse_pkg::OP_PLAN;
        state_d = stat_i.plan_go ? S_TOT_INC : S_FRONT_RD;
      end
      S_TOT_INC: begin
        op_o    = rlse_pkg::OP_TOT_INC;
        state_d = S_SHIFT_INIT;
      end
      S_SHIFT_INIT: begin
        op_o    = rlse_pkg::OP_SHIFT_INIT;
        state_d = stat_i.no_shift ? S_FILL : S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        op_o    = rlse_pkg::OP_READ_SHIFT;
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        op_o    = rlse_pkg::OP_WRITE_SHIFT;
        state_d = stat_i.moves_last ? S_FILL : S_SHIFT_RD;
      end
      S_FILL: begin
        op_o    = rlse_pkg::OP_FILL;
        state_d = stat_i.fill_last ? S_RESIZE : S_FILL;
      end
      S_RESIZE: begin
        op_o    = rlse_pkg::OP_RESIZE;
        state_d = S_FRONT_RD;
      end
      S_RESTART: begin
        op_o    = rlse_pkg::OP_RESTART;
        state_d = S_FRONT_RD;
      end
      S_FRONT_RD: begin
        op_o    = rlse_pkg::OP_READ_FRONT;
        state_d = S_BACK_RD;
      end
      S_BACK_RD: begin
        op_o    = rlse_pkg::OP_READ_BACK;
        state_d = S_BACK_USE;
      end
      S_BACK_USE: begin
        op_o    = rlse_pkg::OP_CAP_BACK;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!stat_i.out_busy) begin
          op_o    = rlse_pkg::OP_LOAD_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// File: design/run_length_sequence_editor.sv
// Top level of the run-length sequence editor: sequencer plus datapath.
// Depends on rlse_pkg, rlse_ctrl and rlse_dp.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_item_i  (rlse_pkg::in_item_t)
//   out      output     out_valid_o / out_ready_i out_item_o (rlse_pkg::out_item_t)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item at a time through a single-port run memory with registered read.
// Push/pop update the end run; adding or removing a run also moves the other
// runs, one at a time, when the front end changes.
// Change/query scan the runs in order; a rewrite then reads the neighbours,
// plans, moves the tail run by run and fills in the new runs.
// Reset clears run count, totals and configuration; no memory clearing pass.
// A new item is taken while the previous result waits in the output register.
module run_length_sequence_editor #(
  parameter int unsigned MAX_RUNS    = rlse_pkg::MAX_RUNS_DEF,
  parameter int unsigned SYMBOL_BITS = rlse_pkg::SYMBOL_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rlse_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rlse_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rlse_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [rlse_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rlse_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  rlse_pkg::dp_op_e   op;
  rlse_pkg::dp_stat_t stat;

  rlse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  rlse_dp #(
    .MAX_RUNS    (MAX_RUNS),
    .SYMBOL_BITS (SYMBOL_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
